FILE: rtl/biquad_iir_filter_top_defines.svh
// Assertion macros shared by the biquad checker.
`ifndef BIQUAD_IIR_FILTER_TOP_DEFINES_SVH
`define BIQUAD_IIR_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BQD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BQD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bqd_pkg.sv
// Shared types and constants of the biquad section.
`timescale 1ns / 1ps

package bqd_pkg;

    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0   = 3'd0,
        CFG_B1   = 3'd1,
        CFG_B2   = 3'd2,
        CFG_A1   = 3'd3,
        CFG_A2   = 3'd4,
        CFG_GAIN = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 16'sd16384;

endpackage

FILE: rtl/biquad_iir_filter_top.sv
// Direct form 1 biquad section with one shared multiplier.
`timescale 1ns / 1ps

// Biquad IIR section, direct form 1: y = gain*(b0*x0 + b1*x1 + b2*x2) - (a1*y1 + a2*y2).
// Coefficients and gain are signed Q2.14 registers written through the cfg port (index
// 0..5: b0, b1, b2, a1, a2, gain; other indexes are dropped). The user must write them
// only while the block is idle; the block does not enforce this. The sum is formed
// exactly, rounded half up at 2^(2*COEF_FRAC_BITS) and saturated to SAMPLE_WIDTH bits;
// the saturated value is both the output and the feedback history. Each sample takes six
// passes through the single 16 x (SAMPLE_WIDTH+18) bit multiplier, a rounding and a
// feedback subtract step, and an emit state that saturates and loads the output
// register. s_tready stays low for the whole computation; a finished result waits in the
// output register, and a new sample can be taken while it waits.
module biquad_iir_filter_top #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 14,
    localparam int TDATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // slave side
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TDATA_W-1:0]                 s_tdata,  // sample_in
    // master side
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TDATA_W-1:0]                 m_tdata,  // sample_out
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bqd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bqd_pkg::COEF_W-1:0]         cfg_data
);

    localparam int COEF_W = bqd_pkg::COEF_W;
    localparam int ACC_W  = bqd_pkg::ACC_W;
    localparam int SUM_W  = SAMPLE_WIDTH + COEF_W + 2;
    localparam int PROD_W = COEF_W + SUM_W;

    localparam logic signed [ACC_W-1:0] S_LIM = 64'sd1 <<< 46;
    localparam logic signed [ACC_W-1:0] F_LIM = 64'sd1 <<< (62 - COEF_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ROUND = 64'sd1 <<< (2 * COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - 64'sd1;

    localparam logic [2:0] STEP_B0    = 3'd0;
    localparam logic [2:0] STEP_B1    = 3'd1;
    localparam logic [2:0] STEP_B2    = 3'd2;
    localparam logic [2:0] STEP_A1    = 3'd3;
    localparam logic [2:0] STEP_A2    = 3'd4;
    localparam logic [2:0] STEP_GAIN  = 3'd5;
    localparam logic [2:0] STEP_ROUND = 3'd6;
    localparam logic [2:0] STEP_FB    = 3'd7;

    bqd_pkg::state_t state_reg;
    logic [2:0]      step_reg;

    logic signed [COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg, gain_reg;
    logic signed [SAMPLE_WIDTH-1:0] x0_reg, x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [SUM_W-1:0]  s_reg, f_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [SAMPLE_WIDTH-1:0]  m_data_reg;
    logic                     m_valid_reg;

    logic signed [COEF_W-1:0] mul_coef;
    logic signed [SUM_W-1:0]  mul_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  prod_sum;
    logic signed [ACC_W-1:0]  prod_wide;
    logic signed [ACC_W-1:0]  s_wide, s_clamp, f_wide, f_clamp;
    logic signed [ACC_W-1:0]  y_full, y_sat;
    logic                     emit_fire;

    bqd_mul #(.OP_W(SUM_W)) u_mul (
        .aclk    (aclk),
        .coef    (mul_coef),
        .operand (mul_op),
        .prod    (prod)
    );

    // operand select: the product lands in the cycle after its step
    always_comb begin
        unique case (step_reg)
            STEP_B0: begin
                mul_coef = b0_reg;
                mul_op   = SUM_W'(x0_reg);
            end
            STEP_B1: begin
                mul_coef = b1_reg;
                mul_op   = SUM_W'(x1_reg);
            end
            STEP_B2: begin
                mul_coef = b2_reg;
                mul_op   = SUM_W'(x2_reg);
            end
            STEP_A1: begin
                mul_coef = a1_reg;
                mul_op   = SUM_W'(y1_reg);
            end
            STEP_A2: begin
                mul_coef = a2_reg;
                mul_op   = SUM_W'(y2_reg);
            end
            default: begin
                mul_coef = gain_reg;
                mul_op   = s_reg;
            end
        endcase
    end

    assign prod_sum  = SUM_W'(prod);
    assign prod_wide = ACC_W'(prod);

    assign s_wide  = ACC_W'(s_reg);
    assign s_clamp = (s_wide < -S_LIM) ? -S_LIM : ((s_wide > S_LIM) ? S_LIM : s_wide);
    assign f_wide  = ACC_W'(f_reg);
    assign f_clamp = (f_wide < -F_LIM) ? -F_LIM : ((f_wide > F_LIM) ? F_LIM : f_wide);

    assign y_full = acc_reg >>> (2 * COEF_FRAC_BITS);
    assign y_sat  = (y_full < Y_MIN) ? Y_MIN : ((y_full > Y_MAX) ? Y_MAX : y_full);

    assign emit_fire = (state_reg == bqd_pkg::ST_EMIT) && (!m_valid_reg || m_tready);

    // control and filter history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bqd_pkg::ST_IDLE;
            step_reg    <= STEP_B0;
            m_valid_reg <= 1'b0;
            x1_reg      <= '0;
            x2_reg      <= '0;
            y1_reg      <= '0;
            y2_reg      <= '0;
        end else begin
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                bqd_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= bqd_pkg::ST_CALC;
                        step_reg  <= STEP_B0;
                    end
                end
                bqd_pkg::ST_CALC: begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == STEP_FB) begin
                        state_reg <= bqd_pkg::ST_EMIT;
                    end
                end
                bqd_pkg::ST_EMIT: begin
                    // hold until the output register is free
                    if (emit_fire) begin
                        x2_reg      <= x1_reg;
                        x1_reg      <= x0_reg;
                        y2_reg      <= y1_reg;
                        y1_reg      <= SAMPLE_WIDTH'(y_sat);
                        state_reg   <= bqd_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= bqd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // datapath accumulators
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x0_reg <= s_tdata[SAMPLE_WIDTH-1:0];
        end
        if (state_reg == bqd_pkg::ST_CALC) begin
            unique case (step_reg)
                STEP_B1:    s_reg   <= prod_sum;
                STEP_B2:    s_reg   <= s_reg + prod_sum;
                STEP_A1:    s_reg   <= s_reg + prod_sum;
                STEP_A2: begin
                    s_reg <= SUM_W'(s_clamp);
                    f_reg <= prod_sum;
                end
                STEP_GAIN:  f_reg   <= f_reg + prod_sum;
                STEP_ROUND: begin
                    acc_reg <= prod_wide + ROUND;
                    f_reg   <= SUM_W'(f_clamp);
                end
                STEP_FB:    acc_reg <= acc_reg - (f_wide <<< COEF_FRAC_BITS);
                default: ;
            endcase
        end
        if (emit_fire) begin
            m_data_reg <= SAMPLE_WIDTH'(y_sat);
        end
    end

    // coefficient registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg   <= bqd_pkg::COEF_ONE;
            b1_reg   <= '0;
            b2_reg   <= '0;
            a1_reg   <= '0;
            a2_reg   <= '0;
            gain_reg <= bqd_pkg::COEF_ONE;
        end else if (cfg_valid) begin
            unique case (bqd_pkg::cfg_idx_t'(cfg_index))
                bqd_pkg::CFG_B0:   b0_reg   <= cfg_data;
                bqd_pkg::CFG_B1:   b1_reg   <= cfg_data;
                bqd_pkg::CFG_B2:   b2_reg   <= cfg_data;
                bqd_pkg::CFG_A1:   a1_reg   <= cfg_data;
                bqd_pkg::CFG_A2:   a2_reg   <= cfg_data;
                bqd_pkg::CFG_GAIN: gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready  = (state_reg == bqd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = TDATA_W'(m_data_reg);

endmodule

FILE: rtl/bqd_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module bqd_mul #(
    parameter int OP_W = 34
) (
    input  logic                                  aclk,
    input  logic signed [bqd_pkg::COEF_W-1:0]     coef,
    input  logic signed [OP_W-1:0]                operand,
    output logic signed [bqd_pkg::COEF_W+OP_W-1:0] prod
);

    logic signed [bqd_pkg::COEF_W+OP_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= coef * operand;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/bqd_checker.sv
// Port-level checker for the biquad section, bound to the top level.
`timescale 1ns / 1ps
`include "biquad_iir_filter_top_defines.svh"

module bqd_checker #(
    parameter int TDATA_W = 16
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // a stalled output beat keeps its data
    `BQD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

    // a sample beat closes the input until the computation is done
    `BQD_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "input open right after a sample beat")

    // the multiply sequence keeps the input closed while all its steps run
    `BQD_ASSERT_NEXT(a_busy_span, s_tvalid && s_tready, !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready, "input reopened too early")

    // a fresh result comes only as the block goes idle
    `BQD_ASSERT_NOW(a_result_at_idle, $rose(m_tvalid), s_tready, "result shown while still busy")

endmodule

bind biquad_iir_filter_top bqd_checker #(.TDATA_W(TDATA_W)) u_bqd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/testbench.sv
// Self-checking testbench for the direct form 1 biquad section.
`timescale 1ns / 1ps

module testbench;

    localparam int SW            = 16;
    localparam int FRAC          = 14;
    localparam int DRAIN_CYCLES  = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRESSURE_HOLD = 400;

    // indexes past the last register; the block must drop writes to them
    localparam logic [bqd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [bqd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    // notch-like section: b1 = -1.9308, b2 = 0.96, a1 = -1.9702, a2 = 0.98
    localparam logic signed [bqd_pkg::COEF_W-1:0] NOTCH_B1 = -16'sd31634;
    localparam logic signed [bqd_pkg::COEF_W-1:0] NOTCH_B2 = 16'sd15729;
    localparam logic signed [bqd_pkg::COEF_W-1:0] NOTCH_A1 = -16'sd32280;
    localparam logic signed [bqd_pkg::COEF_W-1:0] NOTCH_A2 = 16'sd16056;

    localparam logic signed [SW-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SW-1:0] SAMPLE_MIN = 16'sh8000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata = '0;     // sample_in
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [SW-1:0] m_tdata;          // sample_out
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bqd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bqd_pkg::COEF_W-1:0]    cfg_data = '0;

    // predictor state: coefficients and filter history
    logic signed [bqd_pkg::COEF_W-1:0] coef_q [0:5];
    logic signed [SW-1:0]     x_hist1, x_hist2, y_hist1, y_hist2;
    logic signed [SW-1:0]     expected_out_q [$];

    int  err_cnt = 0;
    int  idle_cycles = 0;
    int  sink_hold_req = 0;
    bit  src_idle_on = 1'b1;
    bit  sink_idle_on = 1'b1;

    biquad_iir_filter_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Advance the filter by one sample and return the saturated output.
    function automatic logic signed [SW-1:0] biquad_predict(input logic signed [SW-1:0] x);
        longint ff_sum, fb_sum, acc, y;
        ff_sum = longint'(coef_q[bqd_pkg::CFG_B0]) * longint'(x)
               + longint'(coef_q[bqd_pkg::CFG_B1]) * longint'(x_hist1)
               + longint'(coef_q[bqd_pkg::CFG_B2]) * longint'(x_hist2);
        fb_sum = longint'(coef_q[bqd_pkg::CFG_A1]) * longint'(y_hist1)
               + longint'(coef_q[bqd_pkg::CFG_A2]) * longint'(y_hist2);
        acc = longint'(coef_q[bqd_pkg::CFG_GAIN]) * ff_sum - (fb_sum <<< FRAC);
        // round half up at the product scale
        acc = acc + (64'sd1 <<< (2 * FRAC - 1));
        y = acc >>> (2 * FRAC);
        if (y > longint'(SAMPLE_MAX))
            y = longint'(SAMPLE_MAX);
        else if (y < longint'(SAMPLE_MIN))
            y = longint'(SAMPLE_MIN);
        x_hist2 = x_hist1;
        x_hist1 = x;
        y_hist2 = y_hist1;
        y_hist1 = y[SW-1:0];
        return y[SW-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (!src_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [bqd_pkg::COEF_W-1:0] rand_extreme_coef();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return bqd_pkg::COEF_ONE;
        endcase
    endfunction

    // Offer one sample; valid stays high on return so the next beat can follow directly.
    task automatic send_sample(input logic [SW-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        expected_out_q.push_back(biquad_predict(x));
    endtask

    task automatic stop_samples();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_samples();
        while (expected_out_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all six registers in one burst, optionally with a dropped write mixed in.
    task automatic write_coefs(input logic [bqd_pkg::COEF_W-1:0] b0,
                               input logic [bqd_pkg::COEF_W-1:0] b1,
                               input logic [bqd_pkg::COEF_W-1:0] b2,
                               input logic [bqd_pkg::COEF_W-1:0] a1,
                               input logic [bqd_pkg::COEF_W-1:0] a2,
                               input logic [bqd_pkg::COEF_W-1:0] g,
                               input bit poke_unused);
        logic [bqd_pkg::CFG_IDX_W-1:0] idx_list [0:6];
        logic [bqd_pkg::COEF_W-1:0]    val_list [0:6];
        logic [bqd_pkg::CFG_IDX_W-1:0] idx_tmp;
        logic [bqd_pkg::COEF_W-1:0]    val_tmp;
        int n, k;
        idx_list[0] = bqd_pkg::CFG_B0;   val_list[0] = b0;
        idx_list[1] = bqd_pkg::CFG_B1;   val_list[1] = b1;
        idx_list[2] = bqd_pkg::CFG_B2;   val_list[2] = b2;
        idx_list[3] = bqd_pkg::CFG_A1;   val_list[3] = a1;
        idx_list[4] = bqd_pkg::CFG_A2;   val_list[4] = a2;
        idx_list[5] = bqd_pkg::CFG_GAIN; val_list[5] = g;
        n = 6;
        if (poke_unused) begin
            idx_list[6] = $urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO;
            val_list[6] = 16'($urandom);
            k = $urandom_range(0, 6);
            idx_tmp = idx_list[k]; idx_list[k] = idx_list[6]; idx_list[6] = idx_tmp;
            val_tmp = val_list[k]; val_list[k] = val_list[6]; val_list[6] = val_tmp;
            n = 7;
        end
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= val_list[i];
            do @(posedge aclk); while (!(cfg_valid && cfg_ready));
            if (idx_list[i] <= bqd_pkg::CFG_GAIN)
                coef_q[idx_list[i]] = val_list[i];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_passthrough();
        // reset coefficients give y = x
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        wait_drained();
    endtask

    task automatic test_rounding();
        // b0 of one half: odd inputs land exactly on a half and round up
        write_coefs(16'sd8192, '0, '0, '0, '0, bqd_pkg::COEF_ONE, 1'b0);
        send_sample(16'h0001);
        send_sample(16'hffff);
        send_sample(16'h0003);
        send_sample(16'hfffd);
        wait_drained();
    endtask

    task automatic test_saturation();
        write_coefs(16'sh7fff, 16'sh8000, 16'sh7fff, '0, '0, 16'sh8000, 1'b0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        wait_drained();
        // feedback of -2 and just under +2 drives the saturated value around the loop
        write_coefs(bqd_pkg::COEF_ONE, '0, '0, 16'sh8000, 16'sh7fff, bqd_pkg::COEF_ONE, 1'b0);
        send_sample(16'd1000);
        repeat (5) send_sample(16'h0000);
        wait_drained();
    endtask

    task automatic test_notch_and_dropped_writes();
        write_coefs(bqd_pkg::COEF_ONE, NOTCH_B1, NOTCH_B2, NOTCH_A1, NOTCH_A2,
                    bqd_pkg::COEF_ONE, 1'b1);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        send_sample(16'd100);
        send_sample(-16'sd100);
        wait_drained();
    endtask

    task automatic test_random_sections(input int phases, input int items_per_phase);
        logic [bqd_pkg::COEF_W-1:0] c [0:5];
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 3))
                0: begin
                    c[0] = bqd_pkg::COEF_ONE; c[1] = NOTCH_B1; c[2] = NOTCH_B2;
                    c[3] = NOTCH_A1; c[4] = NOTCH_A2; c[5] = 16'($urandom_range(0, 32767));
                end
                1: for (int i = 0; i < 6; i++) c[i] = rand_extreme_coef();
                2: for (int i = 0; i < 6; i++) c[i] = 16'($urandom);
                default: begin
                    // mild feedback keeps the output off the rails most of the time
                    for (int i = 0; i < 3; i++)
                        c[i] = 16'($signed($urandom_range(0, 16384)) - 8192);
                    c[3] = 16'($signed($urandom_range(0, 8192)) - 4096);
                    c[4] = 16'($signed($urandom_range(0, 8192)) - 4096);
                    c[5] = 16'($urandom);
                end
            endcase
            write_coefs(c[0], c[1], c[2], c[3], c[4], c[5], $urandom_range(0, 3) == 0);
            for (int i = 0; i < items_per_phase; i++)
                send_sample(rand_sample());
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        write_coefs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 4095)),
                    16'($urandom_range(0, 4095)), 16'($urandom), 1'b0);
        src_idle_on   = 1'b0;
        sink_hold_req = PRESSURE_HOLD;
        for (int i = 0; i < 30; i++)
            send_sample(rand_sample());
        src_idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_full_rate();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int i = 0; i < 40; i++)
            send_sample(rand_sample());
        wait_drained();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        coef_q[bqd_pkg::CFG_B0]   = bqd_pkg::COEF_ONE;
        coef_q[bqd_pkg::CFG_B1]   = '0;
        coef_q[bqd_pkg::CFG_B2]   = '0;
        coef_q[bqd_pkg::CFG_A1]   = '0;
        coef_q[bqd_pkg::CFG_A2]   = '0;
        coef_q[bqd_pkg::CFG_GAIN] = bqd_pkg::COEF_ONE;
        x_hist1 = '0; x_hist2 = '0; y_hist1 = '0; y_hist2 = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_rounding();
        test_saturation();
        test_notch_and_dropped_writes();
        test_random_sections(6, 100);
        test_backpressure();
        test_full_rate();
        test_random_sections(6, 100);

        stop_samples();
        while (expected_out_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    initial begin
        int n;
        forever begin
            if (sink_hold_req > 0) begin
                n = sink_hold_req;
                sink_hold_req = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else if (sink_idle_on && $urandom_range(0, 99) < 30) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Compare each output beat against the oldest prediction.
    always @(posedge aclk) begin
        logic signed [SW-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_out_q.size() == 0) begin
                $error("sample_out: unexpected beat, expected none, actual %0d",
                       $signed(m_tdata));
                err_cnt++;
            end else begin
                want = expected_out_q.pop_front();
                if (m_tdata !== want) begin
                    $error("sample_out: expected %0d, actual %0d", want, $signed(m_tdata));
                    err_cnt++;
                end
            end
        end
    end

    // End the run if no channel moves a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
